@@ rtl/sorted_insert_list_core_assert.svh @@
// ----------------------------------------------------------------------------
// Sorted insert list assertion macros
// Concurrent checks on clk with rst_n low disabling them; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_LIST_CORE_ASSERT_SVH
`define SORTED_INSERT_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SIL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define SIL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIL_ASSERT_ALWAYS(label, expr, msg)
`define SIL_ASSERT_IMPLIES(label, ante, cons, msg)
`define SIL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/sil_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted insert list package
// Shared codes, state type and the control word broadcast to the cell chain.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_READ_UP   = 2'd1;
    localparam logic [1:0] OP_READ_DOWN = 2'd2;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_ENTRY    = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_ROT_FWD = 2'd2,
        CELL_ROT_BWD = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] ins_value;
    } cell_ctrl_t;

endpackage

@@ rtl/sil_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted insert list cell
// Holds one entry; on insert it shifts or captures, on readout it rotates.
// ----------------------------------------------------------------------------
module sil_cell
    import sil_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         held,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic                     left_gt,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     gt
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occupied;
    logic                     at_end;
    logic                     is_tail;

    assign occupied = CNT_W'(INDEX) < held;
    assign at_end   = CNT_W'(INDEX) == held;
    assign is_tail  = CNT_W'(INDEX + 1) == held;
    assign gt       = occupied && (ctrl.ins_value < data_reg);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                // shift right behind the insert point, capture at it
                if (gt || at_end)
                begin
                    data_next = left_gt ? left_data : ctrl.ins_value;
                end
            end
            CELL_ROT_FWD:
            begin
                if (occupied)
                begin
                    data_next = is_tail ? head_data : right_data;
                end
            end
            CELL_ROT_BWD:
            begin
                if (occupied)
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/sorted_insert_list_core.sv @@
// ----------------------------------------------------------------------------
// Sorted insert list core
// Keeps up to CAPACITY signed values in ascending order in a chain of cells
// and answers inserts and ascending or descending readouts.
// ----------------------------------------------------------------------------
// An insert, a rejected insert and a read of an empty list each give one
// result. A read of n held values gives n results: the first is registered
// in the read state that follows the read transfer, then one per cycle while
// out_stall is low, and the input is held off for the whole run. The cell
// chain rotates by one place per delivered result and is back in order
// after the run; in_stall stays high until the last result of the run has
// entered the output register. The output register also holds off new
// items while its result is stalled.
`include "sorted_insert_list_core_assert.svh"

module sorted_insert_list_core
    import sil_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] entry_value,
    output logic [4:0]               count,
    output logic                     last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic                     down_reg;
    logic                     down_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    status_t                  out_status_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;
    logic [CNT_W-1:0]         out_count_reg;
    logic [CNT_W-1:0]         out_count_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    cell_ctrl_t               ctrl;
    logic                     out_free;
    logic                     in_xfer;
    logic                     full;
    logic [CNT_W-1:0]         tail_idx_full;
    logic [IDX_W-1:0]         tail_idx;
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] tail_data;
    logic [CNT_W+4:0]         count_ext;

    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic signed [DATA_W-1:0] cell_left  [CAPACITY];
    logic signed [DATA_W-1:0] cell_right [CAPACITY];
    logic [CAPACITY-1:0]      cell_gt;
    logic [CAPACITY-1:0]      cell_left_gt;

    assign out_free      = !out_valid_reg || !out_stall;
    assign in_stall      = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer       = in_valid && !in_stall;
    assign full          = count_reg == CNT_W'(CAPACITY);
    assign tail_idx_full = count_reg - 1'b1;
    assign tail_idx      = tail_idx_full[IDX_W-1:0];
    assign head_data     = cell_data[0];
    assign tail_data     = cell_data[tail_idx];

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            // wrap the tail into the head on a descending rotation
            assign cell_left[i]    = tail_data;
            assign cell_left_gt[i] = 1'b0;
        end
        else
        begin : g_inner
            assign cell_left[i]    = cell_data[i-1];
            assign cell_left_gt[i] = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign cell_right[i] = head_data;
        end
        else
        begin : g_body
            assign cell_right[i] = cell_data[i+1];
        end

        sil_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .held       (count_reg),
            .left_data  (cell_left[i]),
            .left_gt    (cell_left_gt[i]),
            .right_data (cell_right[i]),
            .head_data  (head_data),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (operation == OP_READ_UP || operation == OP_READ_DOWN)
                    && count_reg != '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free && remain_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        ctrl.op         = CELL_HOLD;
        ctrl.ins_value  = value;
        count_next      = count_reg;
        remain_next     = remain_reg;
        down_next       = down_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (operation) inside
                        OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_last_next  = 1'b1;
                            if (full)
                            begin
                                out_status_next = STATUS_FULL;
                                out_count_next  = count_reg;
                            end
                            else
                            begin
                                ctrl.op         = CELL_INSERT;
                                count_next      = count_reg + 1'b1;
                                out_status_next = STATUS_INSERTED;
                                out_count_next  = count_reg + 1'b1;
                            end
                        end
                        OP_READ_UP, OP_READ_DOWN:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                                out_value_next  = '0;
                                out_count_next  = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                down_next   = operation == OP_READ_DOWN;
                            end
                        end
                        default:
                        begin
                            // drop the unused code
                            ctrl.op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_ENTRY;
                    out_value_next  = down_reg ? tail_data : head_data;
                    out_count_next  = count_reg;
                    out_last_next   = remain_reg == CNT_W'(1);
                    ctrl.op         = down_reg ? CELL_ROT_BWD : CELL_ROT_FWD;
                    remain_next     = remain_reg - 1'b1;
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign count_ext   = {5'b0, out_count_reg};
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_value = out_value_reg;
    assign count       = count_ext[4:0];
    assign last        = out_last_reg;

    // ---------------- assertions ----------------
    `SIL_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")

    `SIL_ASSERT_IMPLIES(a_read_blocks_input, state_reg == ST_READ, in_stall,
                        "input open during readout")

    `SIL_ASSERT_IMPLIES(a_read_remain, state_reg == ST_READ, remain_reg != '0,
                        "readout with nothing left")

    `SIL_ASSERT_NEXT(a_insert_count, in_xfer && operation == OP_INSERT && !full,
                     count_reg == $past(count_reg) + 1'b1,
                     "insert did not advance count")

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Sorted insert list core testbench
// Drives inserts, ascending and descending readouts and the unused operation
// code through the valid/stall channels with random idle bursts on both sides.
// A shadow copy of the sorted list predicts every result, and each result
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import sil_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_FROM   = 340;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_AT     = 220;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] entry_value;
        logic [4:0]               count;
        logic                     last;
    } list_result_t;

    class sorted_list_scoreboard;
        logic signed [DATA_W-1:0] shadow_list [CAPACITY];
        int                       shadow_count;
        list_result_t             due_results [$];
        int                       mismatches;

        function new();
            shadow_count = 0;
            mismatches   = 0;
        endfunction

        function void push_result(status_t st, logic signed [DATA_W-1:0] v, int cnt,
                                  logic lst);
            list_result_t r;
            r.status      = st;
            r.entry_value = v;
            r.count       = 5'(cnt);
            r.last        = lst;
            due_results.push_back(r);
        endfunction

        // Note an accepted item and queue the results it causes.
        function void apply_item(logic [1:0] op, logic signed [DATA_W-1:0] v);
            int pos;
            if (op == OP_INSERT) begin
                if (shadow_count >= CAPACITY) begin
                    push_result(STATUS_FULL, '0, shadow_count, 1'b1);
                end
                else begin
                    // place after every smaller or equal value
                    pos = 0;
                    while (pos < shadow_count && !(v < shadow_list[pos]))
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = v;
                    shadow_count++;
                    push_result(STATUS_INSERTED, '0, shadow_count, 1'b1);
                end
            end
            else if (op == OP_READ_UP || op == OP_READ_DOWN) begin
                if (shadow_count == 0) begin
                    push_result(STATUS_EMPTY, '0, 0, 1'b1);
                end
                else begin
                    for (int i = 0; i < shadow_count; i++)
                        push_result(STATUS_ENTRY,
                                    (op == OP_READ_UP) ? shadow_list[i]
                                                       : shadow_list[shadow_count-1-i],
                                    shadow_count, i == shadow_count - 1);
                end
            end
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d value %0d count %0d last %0d",
                             got.status, got.entry_value, got.count, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.entry_value !== want.entry_value ||
                got.count !== want.count || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: expected status %0d value %0d count %0d last %0d",
                             want.status, want.entry_value, want.count, want.last);
                    $display("          got      status %0d value %0d count %0d last %0d",
                             got.status, got.entry_value, got.count, got.last);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = OP_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b1;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic [4:0]               count;
    logic                     last;

    sorted_list_scoreboard list_check;
    logic                  long_hold_req = 1'b0;
    logic                  quiet_phase   = 1'b0;

    sorted_insert_list_core #(.CAPACITY(CAPACITY)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_value (entry_value),
        .count       (count),
        .last        (last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        list_check.apply_item(op, v);
    endtask

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 4) - 2;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin : sender
        int                       done;
        int                       pick;
        logic [1:0]               op;
        list_check = new();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused code, extremes and equal values
        send_item(OP_READ_UP, $urandom);
        send_item(OP_READ_DOWN, $urandom);
        send_item(OP_UNUSED, $urandom);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sd1);
        send_item(OP_INSERT, 32'sh8000_0000);
        send_item(OP_READ_UP, $urandom);
        send_item(OP_READ_DOWN, $urandom);
        send_item(OP_UNUSED, $urandom);

        // random mix; the list fills up early and then rejects inserts
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done == HOLD_AT)
                long_hold_req = 1'b1;
            if (done == DRAIN_AT) begin
                idle_input(1);
                while (list_check.pending() != 0)
                    @(posedge clk);
            end
            if (done >= QUIET_FROM)
                quiet_phase = 1'b1;
            if (!quiet_phase && !(done >= HOLD_AT && done < HOLD_AT + 30) &&
                $urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 16));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                op = OP_UNUSED;
            else if (pick < 50)
                op = OP_INSERT;
            else if (pick < 75)
                op = OP_READ_UP;
            else
                op = OP_READ_DOWN;
            send_item(op, pick_value());
            if (op != OP_UNUSED)
                done++;
        end
        in_valid <= 1'b0;

        while (list_check.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (list_check.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin : receiver
        int           burst_left;
        int           hold_left;
        list_result_t got;
        burst_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.status      = status_t'(status);
                got.entry_value = entry_value;
                got.count       = count;
                got.last        = last;
                list_check.check_result(got);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int still_cycles;
        still_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                still_cycles = 0;
            else
                still_cycles++;
            if (still_cycles >= STALL_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

endmodule
